### rtl/core/fcl_pkg.sv
// Shared types, constants and helper functions of the four-floor lift controller.
// Used by the controller and by its port checker; depends on nothing else.
package fcl_pkg;

    localparam int FIELD_W = 4;
    localparam int FLOOR_W = 2;
    localparam int HOLD_W  = 16;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_GOING = 2'd1,
        PH_HOLD  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        DRV_OFF  = 2'd0,
        DRV_UP   = 2'd1,
        DRV_DOWN = 2'd2
    } t_drive;

    typedef struct packed {
        logic               found;
        logic [FLOOR_W-1:0] pos;
    } t_enc;

    // Priority encoder: the lowest set bit wins.
    function automatic t_enc lowest_set(input logic [FIELD_W-1:0] bits);
        t_enc res;
        res.found = 1'b1;
        res.pos   = '0;
        if (bits[0]) begin
            res.pos = 2'd0;
        end else if (bits[1]) begin
            res.pos = 2'd1;
        end else if (bits[2]) begin
            res.pos = 2'd2;
        end else if (bits[3]) begin
            res.pos = 2'd3;
        end else begin
            res.found = 1'b0;
        end
        return res;
    endfunction

endpackage

### rtl/core/four_floor_lift_controller.sv
// Four-floor lift controller: state update for one sampled tick per transaction.
// Depends on fcl_pkg for the phase and drive types and the priority encoder.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one tick: the call button
//   levels and the floor sensor levels. Output channel (o_out_valid /
//   i_out_ready) returns one result transaction per input transaction with
//   the motor drive, floors, status and pending calls after that tick.
//   The hold length is written through i_cfg_wdata when i_cfg_we is high; the
//   user writes it only while the block is idle, which the block itself does not enforce; it resets to 100 ticks.
//   The result is valid in the cycle after input acceptance. Throughput is
//   one transaction per cycle while the receiver does not stall, set by the
//   single state update stage feeding the result register.
//   Reset (synchronous, active low) clears the call latches, floors, hold
//   counter and motor drive, sets the phase to idle and empties the result
//   register.
//   When the receiver stalls, the result register holds its transaction and
//   o_in_ready drops; it rises again in the cycle the result is taken.
module four_floor_lift_controller #(
    parameter int NUM_FLOORS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fcl_pkg::HOLD_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [fcl_pkg::FIELD_W-1:0] i_call_buttons,
    input  logic [fcl_pkg::FIELD_W-1:0] i_floor_sensors,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_motor_up,
    output logic                       o_motor_down,
    output logic [fcl_pkg::FLOOR_W-1:0] o_current_floor_out,
    output logic [fcl_pkg::FLOOR_W-1:0] o_target_floor_out,
    output logic [1:0]                 o_status,
    output logic [fcl_pkg::FIELD_W-1:0] o_pending_calls
);
    import fcl_pkg::*;

    localparam int FLOOR_LIMIT = (NUM_FLOORS < FIELD_W) ? NUM_FLOORS : FIELD_W;
    localparam logic [FIELD_W-1:0] FLOOR_MASK = FIELD_W'((1 << FLOOR_LIMIT) - 1);

    logic [HOLD_W-1:0]  r_hold_ticks;
    logic [FIELD_W-1:0] r_calls, n_calls;
    t_phase             r_phase, n_phase;
    logic [FLOOR_W-1:0] r_target, n_target;
    logic [FLOOR_W-1:0] r_current, n_current;
    logic [HOLD_W-1:0]  r_hold_cnt, n_hold_cnt;
    t_drive             r_drive, n_drive;
    logic               r_out_valid;

    logic               accept;
    logic [FIELD_W-1:0] buttons;
    logic [FIELD_W-1:0] sensors;
    t_enc               sens_enc;
    t_enc               call_enc;
    logic [FIELD_W-1:0] merged_calls;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign buttons    = i_call_buttons & FLOOR_MASK;
    assign sensors    = i_floor_sensors & FLOOR_MASK;
    assign sens_enc   = lowest_set(sensors);
    assign merged_calls = (r_calls | buttons) & FLOOR_MASK;
    assign call_enc   = lowest_set(merged_calls);

    always_comb begin
        n_current  = sens_enc.found ? sens_enc.pos : r_current;
        n_calls    = r_calls;
        n_phase    = r_phase;
        n_target   = r_target;
        n_hold_cnt = r_hold_cnt;
        n_drive    = r_drive;
        case (r_phase)
            PH_GOING: begin
                if (n_current == r_target) begin
                    n_drive    = DRV_OFF;
                    n_calls    = r_calls & ~(FIELD_W'(1) << r_target);
                    n_hold_cnt = r_hold_ticks;
                    n_phase    = PH_HOLD;
                end
            end
            PH_HOLD: begin
                if (r_hold_cnt <= HOLD_W'(1)) begin
                    n_hold_cnt = '0;
                    n_phase    = PH_IDLE;
                end else begin
                    n_hold_cnt = r_hold_cnt - HOLD_W'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_calls = merged_calls;
                if (call_enc.found) begin
                    n_target = call_enc.pos;
                    if (call_enc.pos > n_current) begin
                        n_drive = DRV_UP;
                    end else if (call_enc.pos < n_current) begin
                        n_drive = DRV_DOWN;
                    end else begin
                        n_drive = DRV_OFF;
                    end
                    n_phase = PH_GOING;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_RESET;
        end else if (i_cfg_we) begin
            r_hold_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calls     <= '0;
            r_phase     <= PH_IDLE;
            r_target    <= '0;
            r_current   <= '0;
            r_hold_cnt  <= '0;
            r_drive     <= DRV_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_calls    <= n_calls;
                r_phase    <= n_phase;
                r_target   <= n_target;
                r_current  <= n_current;
                r_hold_cnt <= n_hold_cnt;
                r_drive    <= n_drive;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_motor_up          = (r_drive == DRV_UP);
    assign o_motor_down        = (r_drive == DRV_DOWN);
    assign o_current_floor_out = r_current;
    assign o_target_floor_out  = r_target;
    assign o_status            = r_phase;
    assign o_pending_calls     = r_calls;

endmodule

### rtl/core/fcl_checker.sv
// Port-level checker for the four-floor lift controller, bound to the top level.
// Depends on fcl_pkg for the phase codes.
module fcl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_motor_up,
    input logic                        o_motor_down,
    input logic [fcl_pkg::FLOOR_W-1:0] o_target_floor_out,
    input logic [1:0]                  o_status,
    input logic [fcl_pkg::FIELD_W-1:0] o_pending_calls
);
    import fcl_pkg::*;

    // The motor never drives both ways at once.
    a_motor_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_motor_up && o_motor_down))
        else $error("motor driven up and down together");

    // The motor runs only while the car travels to its target.
    a_motor_going: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_motor_up || o_motor_down)) |-> (o_status == PH_GOING))
        else $error("motor running outside the going phase");

    // While holding, the served call has been cleared and no new call is latched for it.
    a_hold_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == PH_HOLD)) |->
            (((o_pending_calls >> o_target_floor_out) & 4'd1) == 4'd0))
        else $error("served call still pending during hold");

    // A stalled result transaction stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_pending_calls)))
        else $error("stalled result transaction changed");

endmodule

bind four_floor_lift_controller fcl_checker u_fcl_checker (.*);

### tb/four_floor_lift_controller_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the four-floor lift controller: directed trips, random rides, then a long hold.
// Predicts every result transaction in its own lift model; depends on fcl_pkg and the RTL.
module four_floor_lift_controller_tb;
    import fcl_pkg::*;

    typedef struct packed {
        logic               up;
        logic               down;
        logic [FLOOR_W-1:0] cur;
        logic [FLOOR_W-1:0] tgt;
        logic [1:0]         stat;
        logic [FIELD_W-1:0] pend;
    } t_lift_view;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [HOLD_W-1:0]  cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [FIELD_W-1:0] call_buttons = '0;
    logic [FIELD_W-1:0] floor_sensors = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               motor_up;
    logic               motor_down;
    logic [FLOOR_W-1:0] current_floor;
    logic [FLOOR_W-1:0] target_floor;
    logic [1:0]         lift_status;
    logic [FIELD_W-1:0] pending_calls;

    t_phase             lift_phase = PH_IDLE;
    t_drive             lift_drive = DRV_OFF;
    logic [FIELD_W-1:0] call_latch = '0;
    logic [FLOOR_W-1:0] at_floor = '0;
    logic [FLOOR_W-1:0] goal_floor = '0;
    logic [HOLD_W-1:0]  hold_left = '0;
    logic [HOLD_W-1:0]  hold_len = HOLD_RESET;

    t_lift_view expected_views[$];
    t_lift_view seen_view;
    t_lift_view want_view;
    int         errors = 0;
    int         ticks_sent = 0;
    int         results_checked = 0;
    int         arrivals = 0;
    bit         steady = 1'b0;

    four_floor_lift_controller #(
        .NUM_FLOORS(4)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_call_buttons     (call_buttons),
        .i_floor_sensors    (floor_sensors),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_motor_up         (motor_up),
        .o_motor_down       (motor_down),
        .o_current_floor_out(current_floor),
        .o_target_floor_out (target_floor),
        .o_status           (lift_status),
        .o_pending_calls    (pending_calls)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int first_floor(input logic [FIELD_W-1:0] bits);
        for (int i = 0; i < FIELD_W; i++) begin
            if (bits[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void advance_lift(input logic [FIELD_W-1:0] buttons,
                                         input logic [FIELD_W-1:0] sensors);
        int         f;
        t_lift_view v;
        f = first_floor(sensors);
        if (f >= 0) begin
            at_floor = f[FLOOR_W-1:0];
        end
        case (lift_phase)
            PH_GOING: begin
                if (at_floor == goal_floor) begin
                    lift_drive = DRV_OFF;
                    call_latch[goal_floor] = 1'b0;
                    hold_left = hold_len;
                    lift_phase = PH_HOLD;
                    arrivals++;
                end
            end
            PH_HOLD: begin
                if (hold_left <= 1) begin
                    hold_left = '0;
                    lift_phase = PH_IDLE;
                end else begin
                    hold_left = hold_left - 1'b1;
                end
            end
            default: begin
                lift_phase = PH_IDLE;
                call_latch = call_latch | buttons;
                f = first_floor(call_latch);
                if (f >= 0) begin
                    goal_floor = f[FLOOR_W-1:0];
                    if (goal_floor > at_floor) begin
                        lift_drive = DRV_UP;
                    end else if (goal_floor < at_floor) begin
                        lift_drive = DRV_DOWN;
                    end else begin
                        lift_drive = DRV_OFF;
                    end
                    lift_phase = PH_GOING;
                end
            end
        endcase
        v.up   = (lift_drive == DRV_UP);
        v.down = (lift_drive == DRV_DOWN);
        v.cur  = at_floor;
        v.tgt  = goal_floor;
        v.stat = lift_phase;
        v.pend = call_latch;
        expected_views.push_back(v);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(negedge i_clk) begin
        out_ready <= steady || ($urandom_range(99) >= 17);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            seen_view = {motor_up, motor_down, current_floor, target_floor, lift_status,
                         pending_calls};
            if (expected_views.size() == 0) begin
                $display("%0t: result transaction with none expected, actual %h",
                         $time, seen_view);
                errors++;
            end else begin
                want_view = expected_views.pop_front();
                results_checked++;
                check_field("motor_up", want_view.up, seen_view.up);
                check_field("motor_down", want_view.down, seen_view.down);
                check_field("current_floor", want_view.cur, seen_view.cur);
                check_field("target_floor", want_view.tgt, seen_view.tgt);
                check_field("status", want_view.stat, seen_view.stat);
                check_field("pending_calls", want_view.pend, seen_view.pend);
            end
        end
    end

    task automatic send_tick(input logic [FIELD_W-1:0] buttons,
                             input logic [FIELD_W-1:0] sensors);
        while (!steady && $urandom_range(99) < 17) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid      <= 1'b1;
        call_buttons  <= buttons;
        floor_sensors <= sensors;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        advance_lift(buttons, sensors);
        ticks_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_views.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] value);
        settle();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        hold_len = value;
    endtask

    task automatic test_idle_sensors();
        write_hold('0);
        send_tick(4'b0000, 4'b0000);
        send_tick(4'b0000, 4'b0100);
        send_tick(4'b0000, 4'b0000);
    endtask

    task automatic test_same_floor_call();
        send_tick(4'b0100, 4'b0100);
        send_tick(4'b1111, 4'b0000);
        send_tick(4'b0000, 4'b0000);
    endtask

    task automatic test_up_trip();
        send_tick(4'b1000, 4'b0000);
        send_tick(4'b0001, 4'b0000);
        send_tick(4'b0000, 4'b1100);
        send_tick(4'b0000, 4'b1000);
        send_tick(4'b0000, 4'b0000);
    endtask

    task automatic test_down_trip_and_pending();
        send_tick(4'b0011, 4'b0000);
        send_tick(4'b0000, 4'b0100);
        send_tick(4'b0000, 4'b1111);
        send_tick(4'b0000, 4'b0000);
        send_tick(4'b0000, 4'b0010);
        send_tick(4'b0000, 4'b0000);
        send_tick(4'b0010, 4'b0010);
        send_tick(4'b0000, 4'b0000);
        send_tick(4'b0000, 4'b0000);
    endtask

    task automatic test_hold_count();
        write_hold(16'd3);
        send_tick(4'b0001, 4'b0000);
        send_tick(4'b0000, 4'b0001);
        send_tick(4'b1111, 4'b0000);
        send_tick(4'b1111, 4'b0000);
        send_tick(4'b0000, 4'b0000);
    endtask

    task automatic random_ride(input int count);
        logic [FIELD_W-1:0] buttons;
        logic [FIELD_W-1:0] sensors;
        int                 step;
        for (int n = 0; n < count; n++) begin
            buttons = '0;
            if ($urandom_range(99) < 30) begin
                buttons = FIELD_W'($urandom_range(15));
            end
            step = int'(at_floor);
            if (lift_phase == PH_GOING && $urandom_range(1) == 1) begin
                if (goal_floor > at_floor) begin
                    step++;
                end else if (goal_floor < at_floor) begin
                    step--;
                end
            end
            case ($urandom_range(9))
                0: sensors = FIELD_W'($urandom_range(15));
                1, 2, 3: sensors = '0;
                default: sensors = 4'b0001 << step;
            endcase
            send_tick(buttons, sensors);
        end
    endtask

    task automatic test_random_rides();
        logic [HOLD_W-1:0] value;
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(5))
                0: value = '0;
                1: value = 16'd1;
                2: value = HOLD_RESET;
                default: value = HOLD_W'($urandom_range(2, 6));
            endcase
            steady = (p == 3);
            write_hold(value);
            random_ride(110);
        end
        steady = 1'b0;
    endtask

    task automatic test_long_hold();
        while (lift_phase != PH_IDLE) begin
            send_tick(4'b0000, 4'b0001 << goal_floor);
        end
        write_hold(16'hFFFF);
        send_tick(4'b1000, 4'b0000);
        while (lift_phase != PH_HOLD) begin
            send_tick(4'b0000, 4'b0001 << goal_floor);
        end
        for (int n = 0; n < 20; n++) begin
            send_tick(FIELD_W'($urandom_range(15)), FIELD_W'($urandom_range(15)));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_sensors();
        test_same_floor_call();
        test_up_trip();
        test_down_trip_and_pending();
        test_hold_count();
        test_random_rides();
        test_long_hold();

        @(negedge i_clk);
        in_valid <= 1'b0;
        for (int w = 0; w < 200 && expected_views.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (expected_views.size() != 0) begin
            $display("%0t: %0d expected result transactions never arrived",
                     $time, expected_views.size());
            errors += expected_views.size();
        end
        $display("Sent %0d ticks and checked %0d results over %0d arrivals,",
                 ticks_sent, results_checked, arrivals);
        $display("with hold lengths from 0 to 65535 and random stalls on both channels.");
        if (errors == 0) begin
            $display("four_floor_lift_controller verification clean");
        end else begin
            $display("four_floor_lift_controller verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("four_floor_lift_controller verification failed");
        $finish;
    end

endmodule

### files.f
rtl/core/fcl_pkg.sv
rtl/core/four_floor_lift_controller.sv
rtl/core/fcl_checker.sv
tb/four_floor_lift_controller_tb.sv
